// ===== hw/rtl/rmv_pkg.sv =====
// Shared types and constants for the running mean and variance unit.
package rmv_pkg;

  localparam int METRICS = 32;
  localparam int IDX_W = 5;
  localparam int CNT_W = 16;
  localparam int MEAN_W = 48;
  localparam int M2_W = 64;
  localparam logic [CNT_W-1:0] MAX_RUNS = 16'd65535;

  typedef struct packed {
    logic [IDX_W-1:0] metric_index;
    logic [31:0]      sample;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_metric;
    logic [15:0]      sample_count;
    logic [31:0]      mean;
    logic [63:0]      variance;
    logic [31:0]      std_dev;
    logic             variance_valid;
  } out_item_t;

endpackage

// ===== hw/rtl/running_mean_variance_unit.sv =====
// Per-metric Welford running mean and sample variance, state in one synchronous memory.
//
// Input channel in_valid/in_ready/in_data carries one sample per transfer for
// one of 32 metrics. Results leave on out_valid/out_ready/out_data, one per
// sample with last set: count, mean, variance, standard deviation, valid flag.
// Items are processed one at a time; in_ready is high only while idle.
// Each sample passes the memory read, then, below the run limit, the 64-step
// bit-serial divider that forms the mean step and a 48x16 multiply.
// A sample with last set and two or more samples adds a second 64-step divide
// for M2/(n-1), skipped when M2 has saturated, and a 32-step square root.
// A sample whose run already holds 65535 samples only reads out on last.
// The output register holds a result until taken; the next sample is accepted
// meanwhile, and a new result waits in its final state while the register is
// still full. Reset clears the per-entry valid bits, so all accumulators read
// as zero at once with no clearing pass; a finished run clears its bit.
module running_mean_variance_unit
  import rmv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_MEAN = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_VDIV = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam int ENT_W = CNT_W + MEAN_W + M2_W;

  logic [3:0] state_r;
  logic [ENT_W-1:0] mem [METRICS];
  logic [ENT_W-1:0] mem_q_r;
  logic [METRICS-1:0] vld_r;
  logic vld_q_r;
  logic mem_we;
  logic mem_clr;

  logic [IDX_W-1:0] idx_r;
  logic [MEAN_W-1:0] x_r;
  logic last_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MEAN_W-1:0] mean_r;
  logic [M2_W-1:0] m2_r;
  logic [MEAN_W-1:0] dold_r;
  logic neg_r;
  logic [MEAN_W-1:0] mul_a_r;
  logic [MEAN_W-1:0] mul_b_r;
  logic [95:0] acc_r;
  logic [6:0] step_r;
  logic [15:0] dvs_r;
  logic [15:0] rem_r;
  logic [63:0] quo_r;
  logic [63:0] var_r;
  logic [63:0] sv_r;
  logic [33:0] srem_r;
  logic [31:0] root_r;
  logic out_valid_r;
  out_item_t out_data_r;

  logic [CNT_W-1:0] rd_cnt;
  logic [MEAN_W-1:0] rd_mean;
  logic [M2_W-1:0] rd_m2;
  logic [16:0] rem_s;
  logic [35:0] srem_s;
  logic [35:0] trial;
  logic [64:0] m2_sum;
  logic [63:0] prod_hi;
  logic [MEAN_W-1:0] div_quo;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  assign rd_cnt = vld_q_r ? mem_q_r[ENT_W-1 -: CNT_W] : '0;
  assign rd_mean = vld_q_r ? mem_q_r[M2_W +: MEAN_W] : '0;
  assign rd_m2 = vld_q_r ? mem_q_r[M2_W-1:0] : '0;

  assign rem_s = {rem_r, quo_r[63]};
  assign srem_s = {srem_r, sv_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign prod_hi = acc_r[95:32];
  assign m2_sum = {1'b0, m2_r} + {1'b0, prod_hi};
  assign div_quo = quo_r[MEAN_W-1:0];

  assign mem_we = (state_r == S_FIN) && !last_r;
  assign mem_clr = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem_q_r <= mem[in_data.metric_index];
      vld_q_r <= vld_r[in_data.metric_index];
    end
    if (mem_we) begin
      mem[idx_r] <= {cnt_r, mean_r, m2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[idx_r] <= 1'b1;
    end else if (mem_clr) begin
      vld_r[idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            idx_r <= in_data.metric_index;
            x_r <= {in_data.sample, 16'd0};
            last_r <= in_data.last;
            state_r <= (32'(in_data.metric_index) < METRICS) ? S_RD : S_IDLE;
          end
        end
        S_RD: begin
          mean_r <= rd_mean;
          m2_r <= rd_m2;
          if (rd_cnt < MAX_RUNS) begin
            cnt_r <= rd_cnt + 16'd1;
            neg_r <= x_r < rd_mean;
            dold_r <= (x_r < rd_mean) ? rd_mean - x_r : x_r - rd_mean;
            quo_r <= {16'd0, ((x_r < rd_mean) ? rd_mean - x_r : x_r - rd_mean)};
            rem_r <= '0;
            dvs_r <= rd_cnt + 16'd1;
            step_r <= 7'd64;
            state_r <= S_DIV;
          end else begin
            cnt_r <= rd_cnt;
            state_r <= S_FIN;
          end
        end
        S_DIV, S_VDIV: begin
          if (rem_s >= {1'b0, dvs_r}) begin
            rem_r <= 16'(rem_s - {1'b0, dvs_r});
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_s[15:0];
            quo_r <= {quo_r[62:0], 1'b0};
          end
          step_r <= step_r - 7'd1;
          if (step_r == 7'd1) begin
            state_r <= (state_r == S_DIV) ? S_MEAN : S_SQRT;
          end
          if (state_r == S_VDIV) begin
            srem_r <= '0;
            root_r <= '0;
          end
        end
        S_MEAN: begin
          mean_r <= neg_r ? mean_r - div_quo : mean_r + div_quo;
          mul_a_r <= dold_r;
          mul_b_r <= dold_r - div_quo;
          acc_r <= '0;
          step_r <= 7'd3;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= {acc_r[79:0], 16'd0} + 96'(mul_a_r * mul_b_r[47:32]);
          mul_b_r <= {mul_b_r[31:0], 16'd0};
          step_r <= step_r - 7'd1;
          if (step_r == 7'd1) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          m2_r <= m2_sum[64] ? '1 : m2_sum[63:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (cnt_r >= 16'd2) begin
            if (m2_r == '1) begin
              sv_r <= '1;
              var_r <= '1;
              srem_r <= '0;
              root_r <= '0;
              step_r <= 7'd32;
              state_r <= S_SQRT;
            end else begin
              quo_r <= m2_r;
              rem_r <= '0;
              dvs_r <= cnt_r - 16'd1;
              step_r <= 7'd64;
              state_r <= S_VDIV;
            end
          end else begin
            var_r <= '0;
            root_r <= '0;
            state_r <= S_OUT;
          end
        end
        S_SQRT: begin
          if (step_r == 7'd0) begin
            sv_r <= quo_r;
            var_r <= quo_r;
            step_r <= 7'd32;
          end else begin
            if (srem_s >= trial) begin
              srem_r <= 34'(srem_s - trial);
              root_r <= {root_r[30:0], 1'b1};
            end else begin
              srem_r <= srem_s[33:0];
              root_r <= {root_r[30:0], 1'b0};
            end
            sv_r <= {sv_r[61:0], 2'b00};
            step_r <= step_r - 7'd1;
            if (step_r == 7'd1) begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r.result_metric <= idx_r;
            out_data_r.sample_count <= cnt_r;
            out_data_r.mean <= mean_r[47:16];
            out_data_r.variance <= var_r;
            out_data_r.std_dev <= root_r;
            out_data_r.variance_valid <= cnt_r >= 16'd2;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rmv_checker.sv =====
// Port-level checks for the running mean and variance unit, bound into running_mean_variance_unit.
module rmv_checker
  import rmv_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic [63:0] sd_sq;
  assign sd_sq = 64'(out_data.std_dev * out_data.std_dev);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed before transfer");

  a_short_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.variance_valid |->
      out_data.variance == 64'd0 && out_data.std_dev == 32'd0 &&
      out_data.sample_count < 16'd2)
    else $error("short run reports nonzero variance");

  a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.variance_valid == (out_data.sample_count >= 16'd2))
    else $error("variance_valid disagrees with count");

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sample_count != 16'd0)
    else $error("result with zero samples");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sd_sq <= out_data.variance)
    else $error("std_dev too large for variance");

endmodule

bind running_mean_variance_unit rmv_checker u_rmv_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);
